>>> src/mcc_pkg.sv
// shared types, constants and arithmetic helpers for the mcclellan transform unit
// no dependencies
package mcc_pkg;

  localparam int unsigned MaxHalfOrder = 8;
  localparam int unsigned KernelDim    = 3;
  localparam int unsigned FracBits     = 24;
  localparam int unsigned Inset        = (KernelDim - 1) / 2;
  localparam int unsigned MaxTaps      = 2 * MaxHalfOrder + 1;
  localparam int unsigned SideMax      = 2 * MaxHalfOrder * Inset + 1;
  localparam int unsigned Cells        = SideMax * SideMax;
  localparam int unsigned Centre       = MaxHalfOrder * Inset;
  localparam int unsigned KernWords    = KernelDim * KernelDim;

  typedef logic signed [31:0] word_t;
  typedef logic signed [47:0] acc_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [39:0] rnd_t;
  typedef logic [8:0]         addr_t;
  typedef logic [4:0]         coord_t;

  localparam logic [1:0] OpLoadTap  = 2'd0;
  localparam logic [1:0] OpLoadKern = 2'd1;
  localparam logic [1:0] OpCompute  = 2'd2;
  localparam logic [1:0] OpRead     = 2'd3;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadLen = 2'd1;
  localparam logic [1:0] StAsym   = 2'd2;
  localparam logic [1:0] StNone   = 2'd3;

  localparam logic [1:0] CfgTapCount = 2'd0;
  localparam logic [1:0] CfgDefault  = 2'd1;
  localparam logic [1:0] CfgTol      = 2'd2;

  // row-major cell address, row * 17 + col
  function automatic addr_t cell_addr(coord_t r, coord_t c);
    return addr_t'({r, 4'b0000}) + addr_t'(r) + addr_t'(c);
  endfunction

  // built-in kernel [1 2 1; 2 -4 2; 1 2 1] / 8 in q8.24
  function automatic word_t default_kernel(logic [3:0] idx);
    word_t w;
    case (idx) inside
      4'd0, 4'd2, 4'd6, 4'd8: w = 32'sh0020_0000;
      4'd1, 4'd3, 4'd5, 4'd7: w = 32'sh0040_0000;
      4'd4:                   w = 32'shFF80_0000;
      default:                w = '0;
    endcase
    return w;
  endfunction

  // q8.24 product rounding, ties away from zero
  function automatic rnd_t round_q(prod_t p);
    prod_t s;
    s = p + (p[63] ? 64'sd8388607 : 64'sd8388608);
    return s[63:24];
  endfunction

  function automatic word_t sat32(acc_t v);
    word_t w;
    if (v > 48'sd2147483647) begin
      w = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      w = 32'sh8000_0000;
    end else begin
      w = v[31:0];
    end
    return w;
  endfunction

endpackage

>>> src/mcc_ram.sv
// generic single write port ram with registered read
// no dependencies
module mcc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 289,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mcc_mul.sv
// shared signed 32x32 multiplier with registered product
// depends on mcc_pkg
module mcc_mul (
  input  logic                clk_i,
  input  logic                en_i,
  input  mcc_pkg::word_t      a_i,
  input  mcc_pkg::word_t      b_i,
  output mcc_pkg::prod_t      prod_o
);

  mcc_pkg::prod_t prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= mcc_pkg::prod_t'(a_i) * mcc_pkg::prod_t'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

>>> src/mcclellan_2d_fir_transform_unit.sv
// mcclellan 2d fir design: loads, checks, chebyshev recursion, readback
// tap and kernel loads are written from idle on acceptance; a read passes SRd0 and, in range, SRd1
// compute: symmetry checks over the taps, setup of the first polynomials and a0, then per order k
// accumulation into the filter over (2k+1)^2 cells, preceded from k>=2 by a convolution building it
// rate is set by the one shared multiplier and the single read port of each ram
// reset: async active low, registers to their reset values, no result held
// depends on mcc_pkg, mcc_ram, mcc_mul
module mcclellan_2d_fir_transform_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op_i,
  input  logic [4:0]           row_i,
  input  logic [4:0]           col_i,
  input  logic signed [31:0]   value_i,
  // result side, one-cycle strobe
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [4:0]           out_dim_o,
  output logic signed [31:0]   coefficient_o,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  // sequencer states
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SChkA  = 4'd1;
  localparam logic [3:0] SChkB  = 4'd2;
  localparam logic [3:0] SInit  = 4'd3;
  localparam logic [3:0] SAcRd  = 4'd4;
  localparam logic [3:0] SAcMul = 4'd5;
  localparam logic [3:0] SAcWr  = 4'd6;
  localparam logic [3:0] SCvRd  = 4'd7;
  localparam logic [3:0] SCvMul = 4'd8;
  localparam logic [3:0] SCvAcc = 4'd9;
  localparam logic [3:0] SCvPrv = 4'd10;
  localparam logic [3:0] SCvWr  = 4'd11;
  localparam logic [3:0] SRd0   = 4'd12;
  localparam logic [3:0] SRd1   = 4'd13;

  localparam logic [5:0] CentreW = 6'(mcc_pkg::Centre);

  logic [3:0] state_q;

  // configuration registers
  logic [4:0]  tap_count_q;
  logic        use_default_q;
  logic [15:0] tol_q;

  // tap and kernel words
  mcc_pkg::word_t tap_q  [mcc_pkg::MaxTaps];
  mcc_pkg::word_t kern_q [mcc_pkg::KernWords];

  // sequencer registers
  logic                 valid_q;
  logic [4:0]           side_q;
  logic [3:0]           n_q;
  logic [3:0]           k_q;
  mcc_pkg::coord_t      r_q, c_q;
  logic [1:0]           dr_q, dc_q;
  logic [4:0]           i_q;
  mcc_pkg::word_t       hold_q;
  logic                 nz_q;
  mcc_pkg::acc_t        acc_q;
  mcc_pkg::word_t       old_q;
  logic                 tap_ok_q, prev_ok_q;
  logic [1:0]           cur_q;
  mcc_pkg::coord_t      rrow_q, rcol_q;

  // result word registers
  logic                 done_q;
  logic [1:0]           status_q;
  logic [4:0]           dim_q;
  mcc_pkg::word_t       coef_q;

  logic accept;
  assign busy        = (state_q != SIdle);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  function automatic logic in_reach(logic [5:0] x, logic [3:0] reach);
    return (x >= CentreW - 6'(reach)) && (x <= CentreW + 6'(reach));
  endfunction

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q   <= 5'd3;
      use_default_q <= 1'b1;
      tol_q         <= 16'd252;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mcc_pkg::CfgTapCount: tap_count_q   <= cfg_data_i[4:0];
        mcc_pkg::CfgDefault:  use_default_q <= cfg_data_i[0];
        mcc_pkg::CfgTol:      tol_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // tap and kernel loads, taken straight from idle
  // ---------------------------------------------------------------------------
  logic [3:0] load_kidx;
  assign load_kidx = 4'({row_i[1:0], 1'b0}) + 4'(row_i[1:0]) + 4'(col_i[1:0]);

  always_ff @(posedge clk_i) begin
    if (accept && op_i == mcc_pkg::OpLoadTap && col_i < 5'(mcc_pkg::MaxTaps)) begin
      tap_q[col_i] <= value_i;
    end
    if (accept && op_i == mcc_pkg::OpLoadKern &&
        row_i < 5'(mcc_pkg::KernelDim) && col_i < 5'(mcc_pkg::KernelDim)) begin
      kern_q[load_kidx] <= value_i;
    end
  end

  // ---------------------------------------------------------------------------
  // operand selection
  // ---------------------------------------------------------------------------
  logic [4:0]      tap_ridx;
  mcc_pkg::word_t  tap_rd;
  logic [3:0]      kidx;
  mcc_pkg::word_t  kern_word;
  logic [5:0]      pu, pv;

  always_comb begin
    case (state_q)
      SChkB:                tap_ridx = tap_count_q - 5'd1 - i_q;
      SInit:                tap_ridx = 5'(n_q);
      SAcRd, SAcMul, SAcWr: tap_ridx = 5'(n_q) + 5'(k_q);
      default:              tap_ridx = i_q;
    endcase
  end
  assign tap_rd = tap_q[tap_ridx];

  // kernel word at (dr, dc), built-in or loaded
  assign kidx      = 4'({dr_q, 1'b0}) + 4'(dr_q) + 4'(dc_q);
  assign kern_word = use_default_q ? mcc_pkg::default_kernel(kidx) : kern_q[kidx];

  // source cell of the current tap in the current polynomial
  assign pu = 6'(r_q) + 6'd1 - 6'(dr_q);
  assign pv = 6'(c_q) + 6'd1 - 6'(dc_q);

  // ---------------------------------------------------------------------------
  // shared multiplier
  // ---------------------------------------------------------------------------
  logic            mul_en;
  mcc_pkg::word_t  mul_a, mul_b;
  mcc_pkg::prod_t  prod;
  mcc_pkg::word_t  cheb_cur_rd, cheb_prev_rd;

  assign mul_en = (state_q == SCvMul) || (state_q == SAcMul);
  assign mul_a  = (state_q == SCvMul) ? (tap_ok_q ? kern_word : '0) : tap_rd;
  // cells outside the current polynomial's reach may be unwritten or off the grid, so zero both sides
  assign mul_b  = (state_q == SCvMul && !tap_ok_q) ? '0 : cheb_cur_rd;

  mcc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  mcc_pkg::rnd_t  rnd;
  mcc_pkg::acc_t  acc_add;
  mcc_pkg::word_t conv_val, accum_val;

  assign rnd      = mcc_pkg::round_q(prod);
  assign acc_add  = acc_q + mcc_pkg::acc_t'(rnd);
  // next polynomial: twice the convolution less the older one
  assign conv_val = mcc_pkg::sat32((acc_q <<< 1) -
                                   (prev_ok_q ? mcc_pkg::acc_t'(cheb_prev_rd) : '0));
  // filter sum gains ai * pi with ai = 2 * tap
  assign accum_val = mcc_pkg::sat32(mcc_pkg::acc_t'(old_q) +
                                    (mcc_pkg::acc_t'(rnd) <<< 1));

  // ---------------------------------------------------------------------------
  // polynomial rams, roles rotate prev -> cur -> next
  // ---------------------------------------------------------------------------
  logic [1:0]      prev_idx, next_idx;
  logic            cheb_we    [3];
  mcc_pkg::addr_t  cheb_waddr [3];
  mcc_pkg::word_t  cheb_wdata [3];
  mcc_pkg::word_t  cheb_rdata [3];
  mcc_pkg::addr_t  cheb_raddr;

  assign prev_idx = (cur_q == 2'd0) ? 2'd2 : cur_q - 2'd1;
  assign next_idx = (cur_q == 2'd2) ? 2'd0 : cur_q + 2'd1;
  assign cheb_cur_rd  = cheb_rdata[cur_q];
  assign cheb_prev_rd = cheb_rdata[prev_idx];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cheb_we[j]    = 1'b0;
      cheb_waddr[j] = mcc_pkg::cell_addr(r_q, c_q);
      cheb_wdata[j] = conv_val;
      if (state_q == SInit) begin
        if (2'(j) == cur_q) begin
          // first polynomial is the kernel around the centre
          cheb_we[j]    = 1'b1;
          cheb_waddr[j] = mcc_pkg::cell_addr(5'(mcc_pkg::Centre - 1) + 5'(dr_q),
                                             5'(mcc_pkg::Centre - 1) + 5'(dc_q));
          cheb_wdata[j] = kern_word;
        end else if (2'(j) == prev_idx && dr_q == 2'd0 && dc_q == 2'd0) begin
          // zeroth polynomial is one at the centre
          cheb_we[j]    = 1'b1;
          cheb_waddr[j] = mcc_pkg::cell_addr(5'(mcc_pkg::Centre), 5'(mcc_pkg::Centre));
          cheb_wdata[j] = 32'sh0100_0000;
        end
      end else if (state_q == SCvWr && 2'(j) == next_idx) begin
        cheb_we[j] = 1'b1;
      end
    end
  end

  always_comb begin
    case (state_q)
      SCvRd:   cheb_raddr = mcc_pkg::cell_addr(pu[4:0], pv[4:0]);
      default: cheb_raddr = mcc_pkg::cell_addr(r_q, c_q);
    endcase
  end

  for (genvar j = 0; j < 3; j++) begin : g_cheb
    mcc_ram #(
      .Width (32),
      .Depth (mcc_pkg::Cells)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cheb_we[j]),
      .waddr_i (cheb_waddr[j]),
      .wdata_i (cheb_wdata[j]),
      .raddr_i (cheb_raddr),
      .rdata_o (cheb_rdata[j])
    );
  end

  // ---------------------------------------------------------------------------
  // result ram
  // ---------------------------------------------------------------------------
  logic            res_we;
  mcc_pkg::addr_t  res_waddr, res_raddr;
  mcc_pkg::word_t  res_wdata, res_rdata;
  logic [4:0]      half;

  assign half = side_q >> 1;

  always_comb begin
    res_we    = 1'b0;
    res_waddr = mcc_pkg::cell_addr(r_q, c_q);
    res_wdata = accum_val;
    if (state_q == SInit && dr_q == 2'd0 && dc_q == 2'd0) begin
      // filter starts as a0 at the centre
      res_we    = 1'b1;
      res_waddr = mcc_pkg::cell_addr(5'(mcc_pkg::Centre), 5'(mcc_pkg::Centre));
      res_wdata = tap_rd;
    end else if (state_q == SAcWr) begin
      res_we = 1'b1;
    end
  end

  // reads are rotated by 180 degrees
  assign res_raddr = (state_q == SRd0)
                   ? mcc_pkg::cell_addr(5'(mcc_pkg::Centre) + half - rrow_q,
                                        5'(mcc_pkg::Centre) + half - rcol_q)
                   : mcc_pkg::cell_addr(r_q, c_q);

  mcc_ram #(
    .Width (32),
    .Depth (mcc_pkg::Cells)
  ) u_result (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (res_raddr),
    .rdata_o (res_rdata)
  );

  // ---------------------------------------------------------------------------
  // symmetry check
  // ---------------------------------------------------------------------------
  logic signed [32:0] sym_diff;
  logic [32:0]        sym_mag;
  logic               sym_bad, hold_nz, len_bad;

  assign sym_diff = 33'(hold_q) - 33'(tap_rd);
  assign sym_mag  = sym_diff[32] ? 33'(-sym_diff) : 33'(sym_diff);
  assign sym_bad  = sym_mag > 33'(tol_q);
  assign hold_nz  = (hold_q != '0);
  assign len_bad  = (tap_count_q < 5'd3) || !tap_count_q[0] ||
                    (tap_count_q > 5'(mcc_pkg::MaxTaps));

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic [4:0] k_lo, k_hi;
  assign k_lo = 5'(mcc_pkg::Centre) - 5'(k_q);
  assign k_hi = 5'(mcc_pkg::Centre) + 5'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      valid_q   <= 1'b0;
      side_q    <= '0;
      n_q       <= '0;
      k_q       <= '0;
      r_q       <= '0;
      c_q       <= '0;
      dr_q      <= '0;
      dc_q      <= '0;
      i_q       <= '0;
      hold_q    <= '0;
      nz_q      <= 1'b0;
      acc_q     <= '0;
      old_q     <= '0;
      tap_ok_q  <= 1'b0;
      prev_ok_q <= 1'b0;
      cur_q     <= 2'd1;
      rrow_q    <= '0;
      rcol_q    <= '0;
      done_q    <= 1'b0;
      status_q  <= '0;
      dim_q     <= '0;
      coef_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (accept && op_i == mcc_pkg::OpCompute) begin
            valid_q <= 1'b0;
            side_q  <= '0;
            n_q     <= tap_count_q[4:1];
            if (len_bad) begin
              done_q   <= 1'b1;
              status_q <= mcc_pkg::StBadLen;
              dim_q    <= '0;
              coef_q   <= '0;
            end else begin
              i_q     <= '0;
              nz_q    <= 1'b0;
              state_q <= SChkA;
            end
          end else if (accept && op_i == mcc_pkg::OpRead) begin
            rrow_q  <= row_i;
            rcol_q  <= col_i;
            state_q <= SRd0;
          end
        end
        SChkA: begin
          hold_q  <= tap_rd;
          state_q <= SChkB;
        end
        SChkB: begin
          nz_q <= nz_q | hold_nz;
          if (sym_bad || (i_q == tap_count_q - 5'd1 && !(nz_q | hold_nz))) begin
            done_q   <= 1'b1;
            status_q <= mcc_pkg::StAsym;
            dim_q    <= '0;
            coef_q   <= '0;
            state_q  <= SIdle;
          end else if (i_q == tap_count_q - 5'd1) begin
            dr_q    <= '0;
            dc_q    <= '0;
            cur_q   <= 2'd1;
            state_q <= SInit;
          end else begin
            i_q     <= i_q + 5'd1;
            state_q <= SChkA;
          end
        end
        SInit: begin
          if (dc_q == 2'd2) begin
            dc_q <= '0;
            if (dr_q == 2'd2) begin
              dr_q    <= '0;
              k_q     <= 4'd1;
              r_q     <= 5'(mcc_pkg::Centre - 1);
              c_q     <= 5'(mcc_pkg::Centre - 1);
              state_q <= SAcRd;
            end else begin
              dr_q <= dr_q + 2'd1;
            end
          end else begin
            dc_q <= dc_q + 2'd1;
          end
        end
        SAcRd: begin
          state_q <= SAcMul;
        end
        SAcMul: begin
          // cells outside the previous reach still hold nothing
          old_q   <= (in_reach(6'(r_q), k_q - 4'd1) && in_reach(6'(c_q), k_q - 4'd1))
                   ? res_rdata : '0;
          state_q <= SAcWr;
        end
        SAcWr: begin
          if (c_q == k_hi) begin
            c_q <= k_lo;
            if (r_q == k_hi) begin
              if (k_q == n_q) begin
                valid_q  <= 1'b1;
                side_q   <= {n_q, 1'b1};
                done_q   <= 1'b1;
                status_q <= mcc_pkg::StOk;
                dim_q    <= {n_q, 1'b1};
                coef_q   <= '0;
                state_q  <= SIdle;
              end else begin
                k_q     <= k_q + 4'd1;
                r_q     <= k_lo - 5'd1;
                c_q     <= k_lo - 5'd1;
                dr_q    <= '0;
                dc_q    <= '0;
                acc_q   <= '0;
                state_q <= SCvRd;
              end
            end else begin
              r_q     <= r_q + 5'd1;
              state_q <= SAcRd;
            end
          end else begin
            c_q     <= c_q + 5'd1;
            state_q <= SAcRd;
          end
        end
        SCvRd: begin
          tap_ok_q <= in_reach(pu, k_q - 4'd1) && in_reach(pv, k_q - 4'd1);
          state_q  <= SCvMul;
        end
        SCvMul: begin
          state_q <= SCvAcc;
        end
        SCvAcc: begin
          acc_q <= acc_add;
          if (dc_q == 2'd2) begin
            dc_q <= '0;
            if (dr_q == 2'd2) begin
              dr_q    <= '0;
              state_q <= SCvPrv;
            end else begin
              dr_q    <= dr_q + 2'd1;
              state_q <= SCvRd;
            end
          end else begin
            dc_q    <= dc_q + 2'd1;
            state_q <= SCvRd;
          end
        end
        SCvPrv: begin
          prev_ok_q <= in_reach(6'(r_q), k_q - 4'd2) && in_reach(6'(c_q), k_q - 4'd2);
          state_q   <= SCvWr;
        end
        SCvWr: begin
          acc_q <= '0;
          if (c_q == k_hi) begin
            c_q <= k_lo;
            if (r_q == k_hi) begin
              // new polynomial done, rotate roles
              cur_q   <= next_idx;
              r_q     <= k_lo;
              state_q <= SAcRd;
            end else begin
              r_q     <= r_q + 5'd1;
              state_q <= SCvRd;
            end
          end else begin
            c_q     <= c_q + 5'd1;
            state_q <= SCvRd;
          end
        end
        SRd0: begin
          if (!valid_q) begin
            done_q   <= 1'b1;
            status_q <= mcc_pkg::StNone;
            dim_q    <= '0;
            coef_q   <= '0;
            state_q  <= SIdle;
          end else if (rrow_q < side_q && rcol_q < side_q) begin
            state_q <= SRd1;
          end else begin
            done_q   <= 1'b1;
            status_q <= mcc_pkg::StOk;
            dim_q    <= side_q;
            coef_q   <= '0;
            state_q  <= SIdle;
          end
        end
        SRd1: begin
          done_q   <= 1'b1;
          status_q <= mcc_pkg::StOk;
          dim_q    <= side_q;
          coef_q   <= res_rdata;
          state_q  <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_dim_o     = dim_q;
  assign coefficient_o = coef_q;

`ifndef SYNTH
  // a failed compute or an early read carries no side and no coefficient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != mcc_pkg::StOk |-> out_dim_o == '0 && coefficient_o == '0)
    else $error("non-ok word carries data");

  // convolution only runs from the second order on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SCvWr |-> k_q >= 4'd2 && k_q <= n_q)
    else $error("convolution outside order range");

  // ram roles rotate over three buffers only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q != 2'd3)
    else $error("bad polynomial buffer role");

  // a successful compute leaves a valid result of odd side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> side_q[0] && side_q >= 5'd3)
    else $error("valid result with bad side");
`endif

endmodule
